// ===== rtl/core/ihex_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types and constants of the Intel HEX record encoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

  // record and field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OffsetW = 16;
  localparam int unsigned CharW   = 7;

  // defaults for the top level parameters
  localparam int unsigned RecordBytesDefault = 16;
  localparam int unsigned QueueDepthDefault  = 2;

  // one classified image word, handed from the front to the back
  typedef struct packed {
    logic [ByteW-1:0]   data;
    logic               open;      // header comes first
    logic [ByteW-1:0]   rec_len;
    logic [OffsetW-1:0] offset;
    logic               close;     // checksum and newline follow
    logic [ByteW-1:0]   checksum;
    logic               final_rec; // end-of-file record follows
  } cmd_t;

endpackage

// ===== rtl/core/ihex_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_front
// Accepts image words, tracks offset, record fill and checksum, and builds
// one command per word for the character sequencer.
// ----------------------------------------------------------------------------
module ihex_front #(
  parameter int unsigned RecordBytes = ihex_pkg::RecordBytesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ihex_pkg::OffsetW-1:0] cfg_data_i,
  input  logic                         accept_i,
  input  logic [ihex_pkg::ByteW-1:0]   data_byte_i,
  output ihex_pkg::cmd_t               cmd_o
);
  import ihex_pkg::*;

  localparam logic [OffsetW-1:0] RecBytesW = OffsetW'(RecordBytes);
  localparam logic [ByteW-1:0]   RecBytesB = ByteW'(RecordBytes);

  logic [OffsetW-1:0] image_length_q;
  logic [OffsetW-1:0] offset_q, offset_d;
  logic [ByteW-1:0]   sum_q, sum_d;
  logic [ByteW-1:0]   pos_q, pos_d;
  logic [ByteW-1:0]   len_q, len_d;

  logic               open;
  logic [OffsetW-1:0] remaining;
  logic [ByteW-1:0]   new_len;
  logic [ByteW-1:0]   rec_len;
  logic [ByteW-1:0]   base_sum;
  logic [ByteW-1:0]   sum_new;
  logic [ByteW-1:0]   pos_new;
  logic [OffsetW-1:0] offset_inc;
  logic               final_rec;
  logic               close;

  // classify the incoming word
  always_comb begin
    open       = (pos_q == '0);
    remaining  = image_length_q - offset_q;
    if ((remaining == '0) || (remaining > RecBytesW)) begin
      new_len = RecBytesB;
    end else begin
      new_len = remaining[ByteW-1:0];
    end
    rec_len    = open ? new_len : len_q;
    base_sum   = open ? (new_len + offset_q[OffsetW-1:ByteW] + offset_q[ByteW-1:0]) : sum_q;
    sum_new    = base_sum + data_byte_i;
    pos_new    = pos_q + 1'b1;
    offset_inc = offset_q + 1'b1;
    final_rec  = (offset_inc == image_length_q);
    close      = final_rec || (pos_new == rec_len);

    offset_d = final_rec ? '0 : offset_inc;
    pos_d    = close ? '0 : pos_new;
    sum_d    = close ? '0 : sum_new;
    len_d    = final_rec ? '0 : rec_len;
  end

  // command for the back end
  always_comb begin
    cmd_o.data      = data_byte_i;
    cmd_o.open      = open;
    cmd_o.rec_len   = rec_len;
    cmd_o.offset    = offset_q;
    cmd_o.close     = close;
    cmd_o.checksum  = ByteW'(0) - sum_new;
    cmd_o.final_rec = final_rec;
  end

  // length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_length_q <= OffsetW'(1);
    end else if (cfg_we_i) begin
      image_length_q <= cfg_data_i;
    end
  end

  // record tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      sum_q    <= '0;
      pos_q    <= '0;
      len_q    <= '0;
    end else if (accept_i) begin
      offset_q <= offset_d;
      sum_q    <= sum_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
    end
  end

endmodule

// ===== rtl/core/ihex_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_fifo
// Short command queue between the front end and the character sequencer.
// ----------------------------------------------------------------------------
module ihex_fifo #(
  parameter int unsigned Depth = ihex_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ihex_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output ihex_pkg::cmd_t head_o
);
  import ihex_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== rtl/core/ihex_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_back
// Character sequencer: walks each command through header, data, checksum
// and end-of-file characters into a registered output word.
// ----------------------------------------------------------------------------
module ihex_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  ihex_pkg::cmd_t             head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ihex_pkg::CharW-1:0] text_char_o,
  output logic                       last_of_run_o,
  output logic                       end_of_file_o
);
  import ihex_pkg::*;

  localparam int unsigned PosW = 5;

  // character positions within the longest run
  localparam logic [PosW-1:0] PosColon  = 5'd0;
  localparam logic [PosW-1:0] PosLenHi  = 5'd1;
  localparam logic [PosW-1:0] PosLenLo  = 5'd2;
  localparam logic [PosW-1:0] PosOff3   = 5'd3;
  localparam logic [PosW-1:0] PosOff2   = 5'd4;
  localparam logic [PosW-1:0] PosOff1   = 5'd5;
  localparam logic [PosW-1:0] PosOff0   = 5'd6;
  localparam logic [PosW-1:0] PosType1  = 5'd7;
  localparam logic [PosW-1:0] PosType0  = 5'd8;
  localparam logic [PosW-1:0] PosDataHi = 5'd9;
  localparam logic [PosW-1:0] PosDataLo = 5'd10;
  localparam logic [PosW-1:0] PosSumHi  = 5'd11;
  localparam logic [PosW-1:0] PosSumLo  = 5'd12;
  localparam logic [PosW-1:0] PosNl     = 5'd13;
  localparam logic [PosW-1:0] PosEofCol = 5'd14;
  localparam logic [PosW-1:0] PosEofZ0  = 5'd15;
  localparam logic [PosW-1:0] PosEofZ6  = 5'd21;
  localparam logic [PosW-1:0] PosEofOne = 5'd22;
  localparam logic [PosW-1:0] PosEofF0  = 5'd23;
  localparam logic [PosW-1:0] PosEofF1  = 5'd24;
  localparam logic [PosW-1:0] PosEofNl  = 5'd25;

  localparam logic [CharW-1:0] ChColon = 7'h3a;
  localparam logic [CharW-1:0] ChZero  = 7'h30;
  localparam logic [CharW-1:0] ChOne   = 7'h31;
  localparam logic [CharW-1:0] ChUpF   = 7'h46;
  localparam logic [CharW-1:0] ChNl    = 7'h0a;
  localparam logic [CharW-1:0] ChAlpha = 7'h57; // 'a' less ten

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? (ChZero + CharW'(v)) : (ChAlpha + CharW'(v));
  endfunction

  logic            active_q;
  logic [PosW-1:0] pos_q;
  logic [PosW-1:0] cur_pos;
  logic            advance;
  logic [CharW-1:0] ch;
  logic            last;
  logic            eof;

  logic             out_valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic             eof_q;

  assign advance = !out_valid_q || !out_stall_i;
  assign cur_pos = active_q ? pos_q : (head_i.open ? PosColon : PosDataHi);
  assign pop_o   = advance && head_valid_i && last;

  // character select
  always_comb begin
    unique case (cur_pos) inside
      PosColon:              ch = ChColon;
      PosLenHi:              ch = hex_char(head_i.rec_len[7:4]);
      PosLenLo:              ch = hex_char(head_i.rec_len[3:0]);
      PosOff3:               ch = hex_char(head_i.offset[15:12]);
      PosOff2:               ch = hex_char(head_i.offset[11:8]);
      PosOff1:               ch = hex_char(head_i.offset[7:4]);
      PosOff0:               ch = hex_char(head_i.offset[3:0]);
      PosType1, PosType0:    ch = ChZero;
      PosDataHi:             ch = hex_char(head_i.data[7:4]);
      PosDataLo:             ch = hex_char(head_i.data[3:0]);
      PosSumHi:              ch = hex_char(head_i.checksum[7:4]);
      PosSumLo:              ch = hex_char(head_i.checksum[3:0]);
      PosNl, PosEofNl:       ch = ChNl;
      PosEofCol:             ch = ChColon;
      [PosEofZ0:PosEofZ6]:   ch = ChZero;
      PosEofOne:             ch = ChOne;
      PosEofF0, PosEofF1:    ch = ChUpF;
      default:               ch = ChZero;
    endcase
    last = ((cur_pos == PosDataLo) && !head_i.close) ||
           ((cur_pos == PosNl) && !head_i.final_rec) ||
           (cur_pos == PosEofNl);
    eof  = (cur_pos == PosEofNl);
  end

  // sequencer position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= '0;
    end else if (advance && head_valid_i) begin
      active_q <= !last;
      pos_q    <= cur_pos + 1'b1;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && head_valid_i) begin
      char_q <= ch;
      last_q <= last;
      eof_q  <= eof;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign text_char_o   = char_q;
  assign last_of_run_o = last_q;
  assign end_of_file_o = eof_q;

endmodule

// ===== rtl/core/intel_hex_record_encoder.sv =====
`timescale 1ns / 1ps
// first character of a word passes the command queue and then the output register
// throughput: one character per cycle while the output is not stalled, 2 to 26
//   characters per input word, set by the character sequencer
// input stalls only when the command queue is full
// reset clears offset, checksum and record state, queue and output; length reads 1
// ----------------------------------------------------------------------------
// intel_hex_record_encoder
// Intel HEX data record encoder: image words in, lower case hex text out,
// followed by the end-of-file record (with upper case FF) after the final word.
// ----------------------------------------------------------------------------
module intel_hex_record_encoder #(
  parameter int unsigned RecordBytes = ihex_pkg::RecordBytesDefault,
  parameter int unsigned QueueDepth  = ihex_pkg::QueueDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ihex_pkg::OffsetW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ihex_pkg::ByteW-1:0]   data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ihex_pkg::CharW-1:0]   text_char_o,
  output logic                         last_of_run_o,
  output logic                         end_of_file_o
);
  import ihex_pkg::*;

  logic accept;
  logic full;
  logic empty;
  logic pop;
  cmd_t cmd;
  cmd_t head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // front end: classify words
  ihex_front #(
    .RecordBytes(RecordBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .data_byte_i(data_byte_i),
    .cmd_o      (cmd)
  );

  // command queue
  ihex_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (accept),
    .push_cmd_i(cmd),
    .pop_i     (pop),
    .full_o    (full),
    .empty_o   (empty),
    .head_o    (head)
  );

  // back end: emit characters
  ihex_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .text_char_o  (text_char_o),
    .last_of_run_o(last_of_run_o),
    .end_of_file_o(end_of_file_o)
  );

endmodule
